>>> rtl/distance_vector_route_table_core_assert.svh
// assertion macros for the route table core and its checker
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_CORE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define DVRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("route table assertion failed");

// next-cycle implication
`define DVRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("route table assertion failed");

`endif

>>> rtl/dvrt_pkg.sv
// types, constants and codes shared by the route table core
package dvrt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int NUM_PORTS_DEF   = 3;
    localparam int MAX_ADV_DEF     = 25;

    localparam int MAX_PORTS = 3;
    localparam int PORT_W    = 2;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [4:0]  UNREACHABLE   = 5'd16;
    localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0000;
    localparam logic [7:0]  AGE_MAX       = 8'hFF;
    localparam logic [7:0]  AGE_LIMIT_RST = 8'd4;

    typedef enum logic [1:0] {
        OP_ROUTE = 2'd0,
        OP_TICK  = 2'd1,
        OP_ADV   = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_P0_ADDR   = 3'd0,
        REG_P0_MASK   = 3'd1,
        REG_P1_ADDR   = 3'd2,
        REG_P1_MASK   = 3'd3,
        REG_P2_ADDR   = 3'd4,
        REG_P2_MASK   = 3'd5,
        REG_AGE_LIMIT = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PORT,
        ST_READ,
        ST_PROC,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        MODE_ROUTE,
        MODE_UP,
        MODE_LINK,
        MODE_AGE,
        MODE_ADV
    } mode_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] route_address;
        logic [31:0] route_mask;
        logic [4:0]  route_metric;
        logic [31:0] source_ip;
        logic [1:0]  port;
        logic [2:0]  link_up;
    } in_item_t;

    typedef struct packed {
        logic        table_changed;
        logic        table_full;
        logic        entry_valid;
        logic [31:0] out_address;
        logic [31:0] out_mask;
        logic [31:0] out_next_hop;
        logic [4:0]  out_metric;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] destination;
        logic [31:0] netmask;
        logic [31:0] gateway;
        logic [1:0]  port;
        logic [4:0]  hops;
        logic [7:0]  age;
    } entry_t;

    typedef struct packed {
        logic [MAX_PORTS-1:0][31:0] addr;
        logic [MAX_PORTS-1:0][31:0] mask;
        logic [7:0]                 age_limit;
    } cfg_t;

endpackage

>>> rtl/dvrt_mem.sv
// route entry storage, one read and one write port, registered read
module dvrt_mem #(
    parameter int TABLE_DEPTH = dvrt_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output dvrt_pkg::entry_t rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  dvrt_pkg::entry_t wr_data
);
    import dvrt_pkg::*;

    entry_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/dvrt_ctrl.sv
// table walk sequencer: route merge, link and aging ticks, advertisement
module dvrt_ctrl #(
    parameter int TABLE_DEPTH    = dvrt_pkg::TABLE_DEPTH_DEF,
    parameter int NUM_PORTS      = dvrt_pkg::NUM_PORTS_DEF,
    parameter int MAX_ADVERTISED = dvrt_pkg::MAX_ADV_DEF,
    parameter int IDX_W          = $clog2(TABLE_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  dvrt_pkg::in_item_t  item,
    input  dvrt_pkg::cfg_t      cfg,
    input  logic                out_free,
    output logic                emit,
    output dvrt_pkg::out_item_t emit_data,
    output logic                mem_rd_en,
    output logic [IDX_W-1:0]    mem_rd_addr,
    input  dvrt_pkg::entry_t    mem_rd_data,
    output logic                mem_wr_en,
    output logic [IDX_W-1:0]    mem_wr_addr,
    output dvrt_pkg::entry_t    mem_wr_data
);
    import dvrt_pkg::*;

    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    in_item_t               item_reg, item_next;
    logic [4:0]             metric_reg, metric_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [PORT_W-1:0]      pidx_reg, pidx_next;
    logic                   hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    entry_t                 hit_data_reg, hit_data_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   changed_reg, changed_next;
    logic                   full_reg, full_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [MAX_PORTS-1:0]   link_reg, link_next;
    logic [TABLE_DEPTH-1:0] used_reg, used_next;

    logic        route_skip;
    logic [31:0] in_net;
    logic [5:0]  metric_sum;
    logic [4:0]  metric_sat;
    logic [31:0] rnet;
    logic [31:0] pnet;
    logic [31:0] pmask;
    logic [31:0] adv_net;
    logic        cur_used;
    logic        conn;
    logic        later_used;
    logic        adv_last;
    logic        adv_stall;
    logic        link_cur;
    logic [7:0]  age_inc;
    logic        port_done;

    always_comb
    begin
        in_net     = item.route_address & item.route_mask;
        route_skip = (item.route_address == '0) || (item.route_address == LOOPBACK_ADDR);
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            if ((cfg.addr[p] & cfg.mask[p]) == in_net)
            begin
                route_skip = 1'b1;
            end
        end
        metric_sum = {1'b0, item.route_metric} + 6'd1;
        metric_sat = (metric_sum > {1'b0, UNREACHABLE}) ? UNREACHABLE : metric_sum[4:0];
    end

    always_comb
    begin
        rnet     = item_reg.route_address & item_reg.route_mask;
        pmask    = cfg.mask[pidx_reg];
        pnet     = cfg.addr[pidx_reg] & pmask;
        adv_net  = cfg.addr[item_reg.port] & cfg.mask[item_reg.port];
        cur_used = used_reg[idx_reg];
        conn     = cur_used && (mem_rd_data.port == pidx_reg)
                   && (mem_rd_data.gateway == '0) && (mem_rd_data.netmask == pmask)
                   && ((mem_rd_data.destination & pmask) == pnet);
        later_used = 1'b0;
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            if (used_reg[j] && (IDX_W'(j) > idx_reg))
            begin
                later_used = 1'b1;
            end
        end
        adv_last  = (cnt_reg == CNT_W'(MAX_ADVERTISED - 1)) || !later_used;
        adv_stall = (mode_reg == MODE_ADV) && cur_used && !out_free;
        link_cur  = item_reg.link_up[pidx_reg];
        age_inc   = (mem_rd_data.age == AGE_MAX) ? mem_rd_data.age : mem_rd_data.age + 8'd1;
        port_done = (pidx_reg == PORT_W'(NUM_PORTS));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.opcode)
                        OP_ROUTE: state_next = route_skip ? ST_EMIT : ST_READ;
                        OP_TICK:  state_next = ST_PORT;
                        OP_ADV:
                        begin
                            if ((item.port >= PORT_W'(NUM_PORTS)) || (used_reg == '0))
                            begin
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:  state_next = ST_EMIT;
                    endcase
                end
            end
            ST_PORT:
            begin
                if (port_done || link_cur || link_reg[pidx_reg])
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_PROC;
            end
            ST_PROC:
            begin
                if (adv_stall)
                begin
                    state_next = ST_PROC;
                end
                else if ((mode_reg == MODE_ADV) && cur_used && adv_last)
                begin
                    state_next = ST_IDLE;
                end
                else if (idx_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_FINISH:
            begin
                unique case (mode_reg)
                    MODE_UP, MODE_LINK:    state_next = ST_PORT;
                    MODE_ROUTE, MODE_AGE:  state_next = ST_EMIT;
                    default:               state_next = ST_IDLE;
                endcase
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mode_next       = mode_reg;
        item_next       = item_reg;
        metric_next     = metric_reg;
        idx_next        = idx_reg;
        pidx_next       = pidx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_data_next   = hit_data_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        changed_next    = changed_reg;
        full_next       = full_reg;
        cnt_next        = cnt_reg;
        link_next       = link_reg;
        used_next       = used_reg;
        item_ready      = 1'b0;
        emit            = 1'b0;
        emit_data       = '0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = idx_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = idx_reg;
        mem_wr_data     = mem_rd_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    item_next       = item;
                    metric_next     = metric_sat;
                    changed_next    = 1'b0;
                    full_next       = 1'b0;
                    idx_next        = '0;
                    pidx_next       = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    cnt_next        = '0;
                    mode_next       = (item.opcode == OP_ADV) ? MODE_ADV : MODE_ROUTE;
                end
            end
            ST_PORT:
            begin
                idx_next        = '0;
                hit_found_next  = 1'b0;
                free_found_next = 1'b0;
                if (port_done)
                begin
                    mode_next = MODE_AGE;
                end
                else if (!link_reg[pidx_reg] && link_cur)
                begin
                    mode_next = MODE_UP;
                end
                else if (link_reg[pidx_reg])
                begin
                    mode_next = MODE_LINK;
                end
                else
                begin
                    link_next[pidx_reg] = link_cur;
                    pidx_next           = pidx_reg + PORT_W'(1);
                end
            end
            ST_READ:
            begin
                mem_rd_en = 1'b1;
            end
            ST_PROC:
            begin
                if (!free_found_reg && !cur_used)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                case (mode_reg)
                    MODE_ROUTE:
                    begin
                        if (!hit_found_reg && cur_used
                            && ((mem_rd_data.destination & mem_rd_data.netmask) == rnet))
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = idx_reg;
                            hit_data_next  = mem_rd_data;
                        end
                    end
                    MODE_UP:
                    begin
                        if (!hit_found_reg && conn)
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = idx_reg;
                            hit_data_next  = mem_rd_data;
                        end
                    end
                    MODE_LINK:
                    begin
                        if (conn && (mem_rd_data.hops < UNREACHABLE))
                        begin
                            mem_wr_en = 1'b1;
                            if (link_cur)
                            begin
                                mem_wr_data.age = '0;
                            end
                            else
                            begin
                                mem_wr_data.hops = UNREACHABLE;
                                changed_next     = 1'b1;
                            end
                        end
                    end
                    MODE_AGE:
                    begin
                        if (cur_used && (mem_rd_data.hops < UNREACHABLE))
                        begin
                            mem_wr_en       = 1'b1;
                            mem_wr_data.age = age_inc;
                            if (age_inc > cfg.age_limit)
                            begin
                                mem_wr_data.hops = UNREACHABLE;
                                changed_next     = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if (cur_used && out_free)
                        begin
                            emit                   = 1'b1;
                            emit_data.entry_valid  = 1'b1;
                            emit_data.out_address  = mem_rd_data.destination;
                            emit_data.out_mask     = mem_rd_data.netmask;
                            emit_data.out_next_hop = mem_rd_data.gateway;
                            emit_data.out_metric   =
                                ((mem_rd_data.gateway & mem_rd_data.netmask) != adv_net)
                                ? mem_rd_data.hops : UNREACHABLE;
                            emit_data.last         = adv_last;
                            cnt_next               = cnt_reg + CNT_W'(1);
                        end
                    end
                endcase
                if (!adv_stall && (idx_reg != IDX_W'(TABLE_DEPTH - 1)))
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                case (mode_reg)
                    MODE_ROUTE:
                    begin
                        if (hit_found_reg)
                        begin
                            if ((metric_reg < hit_data_reg.hops)
                                || ((hit_data_reg.gateway == item_reg.source_ip)
                                    && (hit_data_reg.hops != metric_reg)))
                            begin
                                mem_wr_en           = 1'b1;
                                mem_wr_addr         = hit_idx_reg;
                                mem_wr_data         = hit_data_reg;
                                mem_wr_data.gateway = item_reg.source_ip;
                                mem_wr_data.port    = item_reg.port;
                                mem_wr_data.hops    = metric_reg;
                                mem_wr_data.age     = '0;
                                changed_next        = 1'b1;
                            end
                        end
                        else if (metric_reg < UNREACHABLE)
                        begin
                            if (free_found_reg)
                            begin
                                mem_wr_en               = 1'b1;
                                mem_wr_addr             = free_idx_reg;
                                mem_wr_data.destination = rnet;
                                mem_wr_data.netmask     = item_reg.route_mask;
                                mem_wr_data.gateway     = item_reg.source_ip;
                                mem_wr_data.port        = item_reg.port;
                                mem_wr_data.hops        = metric_reg;
                                mem_wr_data.age         = '0;
                                used_next[free_idx_reg] = 1'b1;
                                changed_next            = 1'b1;
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                    end
                    MODE_UP:
                    begin
                        if (hit_found_reg)
                        begin
                            mem_wr_en        = 1'b1;
                            mem_wr_addr      = hit_idx_reg;
                            mem_wr_data      = hit_data_reg;
                            mem_wr_data.hops = '0;
                            mem_wr_data.age  = '0;
                            changed_next     = 1'b1;
                        end
                        else if (free_found_reg)
                        begin
                            mem_wr_en               = 1'b1;
                            mem_wr_addr             = free_idx_reg;
                            mem_wr_data.destination = pnet;
                            mem_wr_data.netmask     = pmask;
                            mem_wr_data.gateway     = '0;
                            mem_wr_data.port        = pidx_reg;
                            mem_wr_data.hops        = '0;
                            mem_wr_data.age         = '0;
                            used_next[free_idx_reg] = 1'b1;
                            changed_next            = 1'b1;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                        link_next[pidx_reg] = link_cur;
                        pidx_next           = pidx_reg + PORT_W'(1);
                    end
                    MODE_LINK:
                    begin
                        link_next[pidx_reg] = link_cur;
                        pidx_next           = pidx_reg + PORT_W'(1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit                    = 1'b1;
                    emit_data.table_changed = changed_reg;
                    emit_data.table_full    = full_reg;
                    emit_data.last          = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            link_reg  <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            link_reg  <= link_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        item_reg       <= item_next;
        metric_reg     <= metric_next;
        idx_reg        <= idx_next;
        pidx_reg       <= pidx_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_data_reg   <= hit_data_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        changed_reg    <= changed_next;
        full_reg       <= full_next;
        cnt_reg        <= cnt_next;
    end

endmodule

>>> rtl/distance_vector_route_table_core.sv
// route table core: one table walk per route not skipped, each entry read then processed
// a tick walks once per port whose link is or was up, then once more to age
// advertise reads each entry, stalling on a held result, until the last listed route
// the next transaction is taken once the walk ends, while a result may still wait
// reset zeroes port config, link and valid bits, sets age limit 4; memory not cleared
module distance_vector_route_table_core #(
    parameter int TABLE_DEPTH    = dvrt_pkg::TABLE_DEPTH_DEF,
    parameter int NUM_PORTS      = dvrt_pkg::NUM_PORTS_DEF,
    parameter int MAX_ADVERTISED = dvrt_pkg::MAX_ADV_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  dvrt_pkg::in_item_t                  item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output dvrt_pkg::out_item_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dvrt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data
);
    import dvrt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    cfg_t      cfg_reg, cfg_next;
    logic      result_valid_reg, result_valid_next;
    out_item_t result_reg, result_next;
    logic      out_free;
    logic      emit;
    out_item_t emit_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    entry_t           mem_rd_data;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    entry_t           mem_wr_data;

    assign cfg_ready    = 1'b1;
    assign out_free     = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_P0_ADDR:   cfg_next.addr[0]   = cfg_data;
                REG_P0_MASK:   cfg_next.mask[0]   = cfg_data;
                REG_P1_ADDR:   cfg_next.addr[1]   = cfg_data;
                REG_P1_MASK:   cfg_next.mask[1]   = cfg_data;
                REG_P2_ADDR:   cfg_next.addr[2]   = cfg_data;
                REG_P2_MASK:   cfg_next.mask[2]   = cfg_data;
                REG_AGE_LIMIT: cfg_next.age_limit = cfg_data[7:0];
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (emit)
        begin
            result_valid_next = 1'b1;
            result_next       = emit_data;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg           <= '{addr: '0, mask: '0, age_limit: AGE_LIMIT_RST};
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            cfg_reg           <= cfg_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    dvrt_ctrl #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .NUM_PORTS      (NUM_PORTS),
        .MAX_ADVERTISED (MAX_ADVERTISED),
        .IDX_W          (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .cfg         (cfg_reg),
        .out_free    (out_free),
        .emit        (emit),
        .emit_data   (emit_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    dvrt_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

endmodule

>>> rtl/dvrt_checker.sv
// port-level checker for the route table core and its bind
`include "distance_vector_route_table_core_assert.svh"

module dvrt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic                result_valid,
    input logic                result_ready,
    input dvrt_pkg::out_item_t result
);
    import dvrt_pkg::*;

    `DVRT_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result))
    `DVRT_ASSERT_NOW(a_cfg_always_ready, clk, rst_n, cfg_valid, cfg_ready)
    `DVRT_ASSERT_NOW(a_entry_no_flags, clk, rst_n, result_valid && result.entry_valid, !result.table_changed && !result.table_full)
    `DVRT_ASSERT_NOW(a_status_is_last, clk, rst_n, result_valid && !result.entry_valid, result.last && (result.out_address == '0) && (result.out_metric == '0))

endmodule

bind distance_vector_route_table_core dvrt_checker u_dvrt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
